>>> src/mqm_pkg.sv
// Shared types and codes for the multi-queue manager.
package mqm_pkg;

	localparam int QIDX_W = 10;
	localparam int VAL_W  = 32;
	localparam int CFG_W  = 11;

	localparam logic [1:0] REQ_ENQ   = 2'd0;
	localparam logic [1:0] REQ_FRONT = 2'd1;
	localparam logic [1:0] REQ_DEQ   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [QIDX_W-1:0]       queue_index;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] front_value;
	} rsp_t;

endpackage

>>> src/multi_queue_manager.sv
// Multi-queue manager: linked-list FIFOs sharing one node pool with a recycle stack.
// States from accept to the response load: out-of-range or reserved requests go straight to S_RESP;
// an enqueue into a nonempty queue passes S_LOOK and S_LINK, an ok front S_LOOK and S_FRONT,
// an ok dequeue S_LOOK and S_DEQ, and all other requests S_LOOK alone. One request at a time;
// req_ready returns the cycle after the result is loaded. Queue and node RAM reads are registered.
// After reset a clearing pass over min(NUM_QUEUES, 1024) queue entries empties every queue;
// req_ready stays low until it ends. Config writes are taken at any time.
module multi_queue_manager #(
	parameter int NUM_QUEUES = 1024,
	parameter int POOL_DEPTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  mqm_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output mqm_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [mqm_pkg::CFG_W-1:0] cfg_wdata
);
	import mqm_pkg::*;

	localparam int QD  = (NUM_QUEUES < 1024) ? NUM_QUEUES : 1024;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
	localparam int PW  = $clog2(POOL_DEPTH);

	typedef logic [PW-1:0] ptr_t;

	typedef struct packed {
		logic ne;
		ptr_t head;
		ptr_t tail;
	} qent_t;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_LOOK  = 7'b0000100,
		S_FRONT = 7'b0001000,
		S_DEQ   = 7'b0010000,
		S_LINK  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] cfg_q;
	req_t req_q;
	logic [1:0] status_q;
	logic signed [VAL_W-1:0] fv_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [QAW-1:0] clr_q;
	ptr_t recycle_head_q;
	logic recycle_valid_q;
	logic [PW:0] fresh_next_q;
	ptr_t node_q;
	ptr_t tail_q;
	ptr_t head_q;

	// memories and their registered read data
	qent_t qmem [QD];
	ptr_t lmem [POOL_DEPTH];
	logic [VAL_W-1:0] vmem [POOL_DEPTH];
	qent_t qrd_q;
	ptr_t lrd_q;
	logic [VAL_W-1:0] vrd_q;

	logic q_we, q_re, l_we, l_re, v_we, v_re;
	logic [QAW-1:0] q_waddr, q_raddr;
	qent_t q_wdata;
	ptr_t l_waddr, l_raddr, l_wdata, v_addr;

	logic accept, oob, full, ne_tail;
	logic [16:0] q_ext;
	ptr_t n_pick;
	logic [QAW-1:0] qidx;

	assign accept = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign qidx = req_q.queue_index[QAW-1:0];

	assign q_ext = {7'd0, req.queue_index};
	assign oob = ({1'b0, req.queue_index} >= cfg_q) || (q_ext >= 17'(NUM_QUEUES));

	assign full = !recycle_valid_q && (fresh_next_q == (PW+1)'(POOL_DEPTH));
	assign n_pick = recycle_valid_q ? recycle_head_q : fresh_next_q[PW-1:0];
	assign ne_tail = qrd_q.ne;

	always_comb begin
		q_we = 1'b0;
		q_waddr = qidx;
		q_wdata = qrd_q;
		q_re = accept;
		q_raddr = req.queue_index[QAW-1:0];
		l_we = 1'b0;
		l_waddr = n_pick;
		l_wdata = n_pick;
		l_re = 1'b0;
		l_raddr = recycle_head_q;
		v_we = 1'b0;
		v_re = 1'b0;
		v_addr = n_pick;
		case (state_q)
			S_CLEAR: begin
				q_we = 1'b1;
				q_waddr = clr_q;
				q_wdata = '0;
			end
			S_IDLE: begin
				// fetch the recycle stack's next link in case this is an enqueue
				l_re = accept;
			end
			S_LOOK: begin
				case (req_q.req_type)
					REQ_ENQ: begin
						if (!full) begin
							v_we = 1'b1;
							l_we = 1'b1;
							q_we = 1'b1;
							q_wdata.ne = 1'b1;
							q_wdata.head = ne_tail ? qrd_q.head : n_pick;
							q_wdata.tail = n_pick;
						end
					end
					REQ_FRONT: begin
						v_re = qrd_q.ne;
						v_addr = qrd_q.head;
					end
					REQ_DEQ: begin
						l_re = qrd_q.ne;
						l_raddr = qrd_q.head;
					end
					default: begin
					end
				endcase
			end
			S_LINK: begin
				l_we = 1'b1;
				l_waddr = tail_q;
				l_wdata = node_q;
			end
			S_DEQ: begin
				q_we = 1'b1;
				q_wdata.ne = (head_q != tail_q);
				q_wdata.head = (head_q != tail_q) ? lrd_q : head_q;
				q_wdata.tail = tail_q;
				l_we = 1'b1;
				l_waddr = head_q;
				l_wdata = recycle_valid_q ? recycle_head_q : head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[q_waddr] <= q_wdata;
		end
		if (q_re) begin
			qrd_q <= qmem[q_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			lmem[l_waddr] <= l_wdata;
		end
		if (l_re) begin
			lrd_q <= lmem[l_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[v_addr] <= req_q.value;
		end
		if (v_re) begin
			vrd_q <= vmem[v_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
			recycle_head_q <= '0;
			recycle_valid_q <= 1'b0;
			fresh_next_q <= '0;
			status_q <= ST_OK;
			fv_q <= '0;
			node_q <= '0;
			tail_q <= '0;
			head_q <= '0;
			rsp_q <= '0;
		end else begin
			// in S_RESP the load below owns rsp_valid_q
			if (rsp_valid_q && rsp_ready && (state_q != S_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == QAW'(QD - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						fv_q <= '0;
						if (oob) begin
							status_q <= ST_RANGE;
							state_q <= S_RESP;
						end else begin
							status_q <= ST_OK;
							case (req.req_type)
								REQ_ENQ, REQ_FRONT, REQ_DEQ: state_q <= S_LOOK;
								default: state_q <= S_RESP;
							endcase
						end
					end
				end
				S_LOOK: begin
					head_q <= qrd_q.head;
					tail_q <= qrd_q.tail;
					case (req_q.req_type)
						REQ_ENQ: begin
							if (full) begin
								status_q <= ST_FULL;
								state_q <= S_RESP;
							end else begin
								node_q <= n_pick;
								if (recycle_valid_q) begin
									// a node linking to itself ends the recycle stack
									if (lrd_q == n_pick) begin
										recycle_valid_q <= 1'b0;
									end else begin
										recycle_head_q <= lrd_q;
									end
								end else begin
									fresh_next_q <= fresh_next_q + 1'b1;
								end
								if (ne_tail) begin
									state_q <= S_LINK;
								end else begin
									state_q <= S_RESP;
								end
							end
						end
						REQ_FRONT: begin
							if (qrd_q.ne) begin
								state_q <= S_FRONT;
							end else begin
								status_q <= ST_EMPTY;
								state_q <= S_RESP;
							end
						end
						REQ_DEQ: begin
							if (qrd_q.ne) begin
								state_q <= S_DEQ;
							end else begin
								status_q <= ST_EMPTY;
								state_q <= S_RESP;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_FRONT: begin
					fv_q <= vrd_q;
					state_q <= S_RESP;
				end
				S_LINK: begin
					state_q <= S_RESP;
				end
				S_DEQ: begin
					recycle_head_q <= head_q;
					recycle_valid_q <= 1'b1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status <= status_q;
						rsp_q.front_value <= fv_q;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the multi-queue manager: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
	import mqm_pkg::*;

	localparam int NUM_Q      = 1024;
	localparam int POOL_NODES = 4096;
	localparam int WATCHDOG   = 6000;
	localparam int SETTLE     = 8;

	localparam logic [1:0] REQ_RSVD = 2'd3;

	typedef struct {
		bit               set_cfg;
		logic [CFG_W-1:0] cfg_val;
		req_t             rq;
		bit               typed;
		rsp_t             want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	// shadow of the queue manager state
	logic [CFG_W-1:0]   q_limit;
	logic [11:0]        q_head [NUM_Q];
	logic [11:0]        q_tail [NUM_Q];
	bit                 q_live [NUM_Q];
	logic [VAL_W-1:0]   node_val [POOL_NODES];
	logic [11:0]        node_nxt [POOL_NODES];
	logic [11:0]        free_top;
	bit                 free_any;
	int unsigned        fresh_cnt;

	rsp_t       pending_rsp [$];
	dir_row_t   dir_rows [$];
	logic [9:0] hot_q [4];
	bit         calm_tx;
	bit         calm_rx;
	int         errors;
	int         idle_cycles;

	multi_queue_manager #(
		.NUM_QUEUES(NUM_Q),
		.POOL_DEPTH(POOL_NODES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the shadow state and returns the response it must give.
	function automatic rsp_t apply_request(req_t r);
		rsp_t        o;
		logic [11:0] n;
		logic [11:0] h;
		logic [9:0]  q;
		bit          got;
		o = '0;
		q = r.queue_index;
		n = '0;
		if (q >= q_limit) begin
			o.status = ST_RANGE;
		end else begin
			case (r.req_type)
				REQ_ENQ: begin
					got = 1'b1;
					if (free_any) begin
						n = free_top;
						if (node_nxt[n] == n)
							free_any = 1'b0;
						else
							free_top = node_nxt[n];
					end else if (fresh_cnt < POOL_NODES) begin
						n = fresh_cnt[11:0];
						fresh_cnt++;
					end else begin
						got = 1'b0;
						o.status = ST_FULL;
					end
					if (got) begin
						node_val[n] = r.value;
						node_nxt[n] = n;
						if (q_live[q]) begin
							node_nxt[q_tail[q]] = n;
						end else begin
							q_head[q] = n;
							q_live[q] = 1'b1;
						end
						q_tail[q] = n;
					end
				end
				REQ_FRONT: begin
					if (q_live[q])
						o.front_value = node_val[q_head[q]];
					else
						o.status = ST_EMPTY;
				end
				REQ_DEQ: begin
					if (q_live[q]) begin
						h = q_head[q];
						if (h == q_tail[q])
							q_live[q] = 1'b0;
						else
							q_head[q] = node_nxt[h];
						// freed node goes on top of the recycle stack; the bottom links to itself
						node_nxt[h] = free_any ? free_top : h;
						free_top = h;
						free_any = 1'b1;
					end else begin
						o.status = ST_EMPTY;
					end
				end
				default: ;
			endcase
		end
		return o;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   sel;
		int   lim;
		int   b;
		lim = (q_limit > NUM_Q) ? NUM_Q : q_limit;
		sel = $urandom_range(0, 99);
		if (sel < 80 && lim > 0) begin
			r.queue_index = hot_q[$urandom_range(0, 3)];
		end else if (sel < 90) begin
			r.queue_index = QIDX_W'($urandom);
		end else begin
			b = lim - 1 + $urandom_range(0, 2);
			if (b < 0)
				b = 0;
			if (b > NUM_Q - 1)
				b = NUM_Q - 1;
			r.queue_index = QIDX_W'(b);
		end
		sel = $urandom_range(0, 99);
		if (sel < 45)
			r.req_type = REQ_ENQ;
		else if (sel < 65)
			r.req_type = REQ_FRONT;
		else if (sel < 95)
			r.req_type = REQ_DEQ;
		else
			r.req_type = REQ_RSVD;
		r.value = $urandom;
		return r;
	endfunction

	task automatic pick_hot_queues();
		int lim;
		lim = (q_limit > NUM_Q) ? NUM_Q : q_limit;
		for (int i = 0; i < 4; i++) begin
			if (lim > 0)
				hot_q[i] = QIDX_W'($urandom_range(0, lim - 1));
			else
				hot_q[i] = QIDX_W'($urandom);
		end
		if (lim > 0)
			hot_q[0] = QIDX_W'(lim - 1);
	endtask

	task automatic send(req_t r, bit typed, rsp_t want);
		int   gap;
		rsp_t exp;
		gap = calm_tx ? 0 : $urandom_range(0, 6);
		if ($urandom_range(0, 39) == 0)
			calm_tx = !calm_tx;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		exp = apply_request(r);
		pending_rsp.push_back(typed ? want : exp);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(logic [CFG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		q_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] limit, int count);
		write_limit(limit);
		pick_hot_queues();
		for (int i = 0; i < count; i++)
			send(random_request(), 1'b0, '0);
	endtask

	task automatic add_row(bit set_cfg, int cfgv, logic [1:0] t, int q, logic [31:0] v,
			bit typed, logic [1:0] st, logic [31:0] fv);
		dir_row_t row;
		row.set_cfg = set_cfg;
		row.cfg_val = CFG_W'(cfgv);
		row.rq.req_type = t;
		row.rq.queue_index = QIDX_W'(q);
		row.rq.value = v;
		row.typed = typed;
		row.want.status = st;
		row.want.front_value = fv;
		dir_rows.push_back(row);
	endtask

	// response side: random stalls, then check each beat against the oldest expectation
	initial begin
		int   stall;
		rsp_t want;
		rsp_ready = 1'b0;
		calm_rx = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm_rx ? 0 : $urandom_range(0, 6);
			if ($urandom_range(0, 39) == 0)
				calm_rx = !calm_rx;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (pending_rsp.size() == 0) begin
				$error("response beat with no request outstanding (status %0d)", rsp.status);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.front_value !== want.front_value) begin
					$error("front_value: expected %0d, got %0d",
						want.front_value, rsp.front_value);
					errors++;
				end
			end
		end
	end

	// no beat on either side for too long means a hang
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		req_t r;
		errors = 0;
		idle_cycles = 0;
		calm_tx = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		q_limit = CFG_RESET;
		for (int i = 0; i < NUM_Q; i++) begin
			q_head[i] = '0;
			q_tail[i] = '0;
			q_live[i] = 1'b0;
		end
		for (int i = 0; i < POOL_NODES; i++) begin
			node_val[i] = '0;
			node_nxt[i] = '0;
		end
		free_top = '0;
		free_any = 1'b0;
		fresh_cnt = 0;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty queues after reset, reserved type, value extremes
		add_row(0, 0, REQ_FRONT, 0, 32'h0, 1, ST_EMPTY, 32'h0);
		add_row(0, 0, REQ_DEQ, 0, 32'h0, 1, ST_EMPTY, 32'h0);
		add_row(0, 0, REQ_RSVD, 0, 32'hFFFF_FFFF, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_ENQ, 0, 32'h7FFF_FFFF, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_FRONT, 0, 32'h0, 1, ST_OK, 32'h7FFF_FFFF);
		add_row(0, 0, REQ_ENQ, 0, 32'h8000_0000, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_ENQ, 1023, 32'hFFFF_FFFF, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_FRONT, 1023, 32'h0, 1, ST_OK, 32'hFFFF_FFFF);
		add_row(0, 0, REQ_DEQ, 0, 32'h0, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_FRONT, 0, 32'h0, 1, ST_OK, 32'h8000_0000);
		// head == tail: this dequeue empties the queue
		add_row(0, 0, REQ_DEQ, 0, 32'h0, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_FRONT, 0, 32'h0, 1, ST_EMPTY, 32'h0);
		// two pops off the recycle stack, the second hits its self-linked bottom
		add_row(0, 0, REQ_ENQ, 5, 32'h0, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_ENQ, 5, 32'h1234_5678, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_ENQ, 5, 32'hA5A5_A5A5, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_FRONT, 5, 32'h0, 0, ST_OK, 32'h0);
		add_row(0, 0, REQ_DEQ, 1023, 32'h0, 0, ST_OK, 32'h0);
		add_row(0, 0, REQ_DEQ, 1023, 32'h0, 1, ST_EMPTY, 32'h0);
		add_row(0, 0, REQ_RSVD, 1023, 32'h0, 1, ST_OK, 32'h0);
		// one queue in use
		add_row(1, 1, REQ_FRONT, 1, 32'h0, 1, ST_RANGE, 32'h0);
		add_row(0, 0, REQ_ENQ, 1023, 32'h1, 1, ST_RANGE, 32'h0);
		add_row(0, 0, REQ_ENQ, 0, 32'h5, 1, ST_OK, 32'h0);
		add_row(0, 0, REQ_RSVD, 1, 32'h0, 1, ST_RANGE, 32'h0);
		// zero queues: everything rejected; then limit 2047 lets queue 0 through again
		add_row(1, 0, REQ_FRONT, 0, 32'h0, 1, ST_RANGE, 32'h0);
		add_row(1, 2047, REQ_FRONT, 0, 32'h0, 1, ST_OK, 32'h5);

		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_cfg)
				write_limit(dir_rows[i].cfg_val);
			send(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
		end

		run_phase(11'd1024, 300);
		run_phase(11'd1, 150);
		run_phase(CFG_W'($urandom_range(2, 1023)), 300);
		run_phase(11'd2047, 250);
		run_phase(11'd0, 20);
		run_phase(11'd1024, 200);

		// empty the hot queues, then churn through recycled nodes
		write_limit(11'd1024);
		pick_hot_queues();
		for (int i = 0; i < 40; i++) begin
			r = random_request();
			r.req_type = REQ_DEQ;
			r.queue_index = hot_q[$urandom_range(0, 3)];
			send(r, 1'b0, '0);
		end
		for (int i = 0; i < 50; i++)
			send(random_request(), 1'b0, '0);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
